>>> src/mrpt_pkg.sv
`default_nettype none
package mrpt_pkg;
  localparam int unsigned W = 64;
  localparam int unsigned NSP = 12;
  localparam int unsigned NB = 7;
  localparam int unsigned SPW = 4;
  localparam int unsigned BW = 3;

  typedef logic [W-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIAL, ST_DECOMP, ST_BASE, ST_PMUL, ST_PSQR, ST_CHECK,
    ST_SQR, ST_SQCHK, ST_DONE
  } state_e;

  function automatic logic [5:0] small_prime(input logic [SPW-1:0] i);
    logic [5:0] p;
    case (i)
      4'd0: p = 6'd2;
      4'd1: p = 6'd3;
      4'd2: p = 6'd5;
      4'd3: p = 6'd7;
      4'd4: p = 6'd11;
      4'd5: p = 6'd13;
      4'd6: p = 6'd17;
      4'd7: p = 6'd19;
      4'd8: p = 6'd23;
      4'd9: p = 6'd29;
      4'd10: p = 6'd31;
      4'd11: p = 6'd37;
      default: p = 6'd2;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

>>> src/mrpt_mulmod.sv
`default_nettype none
// bit-serial modular multiply, one bit of b per cycle
module mrpt_mulmod (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire mrpt_pkg::word_t a_i,
  input  wire mrpt_pkg::word_t b_i,
  input  wire mrpt_pkg::word_t m_i,
  output logic               done_o,
  output mrpt_pkg::word_t    r_o
);
  import mrpt_pkg::*;
  word_t r_q, r_d, b_q, b_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  word_t dbl, room1, room2, s1;

  always_comb begin
    room1 = m_i - r_q;
    dbl = (r_q >= room1) ? (r_q - room1) : (r_q + r_q);
    room2 = m_i - a_i;
    s1 = (dbl >= room2) ? (dbl - room2) : (dbl + a_i);
    r_d = r_q;
    b_d = b_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d = '0;
      b_d = b_i;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d = b_q[W-1] ? s1 : dbl;
      b_d = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign r_o = r_q;
endmodule
`default_nettype wire

>>> src/mrpt_trial.sv
`default_nettype none
// remainder of n by a small prime, one byte at a time from the top,
// quotient of each partial remainder by reciprocal multiply
module mrpt_trial (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire mrpt_pkg::word_t n_i,
  input  wire logic [5:0]    p_i,
  output logic               done_o,
  output logic               zero_o
);
  import mrpt_pkg::*;
  logic [5:0] rem_q, rem_d;
  word_t sh_q, sh_d;
  logic [13:0] x_q, x_d, q_q, q_d;
  logic [3:0] cnt_q, cnt_d;
  logic ph_q, ph_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [19:0] recip;
  logic [13:0] x_new;
  logic [33:0] prod;
  logic [19:0] qp;
  logic [13:0] diff;

  // ceil(2^20 / p), exact quotient for any partial remainder below 2^14
  always_comb begin
    case (p_i)
      6'd2: recip = 20'd524288;
      6'd3: recip = 20'd349526;
      6'd5: recip = 20'd209716;
      6'd7: recip = 20'd149797;
      6'd11: recip = 20'd95326;
      6'd13: recip = 20'd80660;
      6'd17: recip = 20'd61681;
      6'd19: recip = 20'd55189;
      6'd23: recip = 20'd45591;
      6'd29: recip = 20'd36158;
      6'd31: recip = 20'd33826;
      default: recip = 20'd28340;
    endcase
  end

  always_comb begin
    x_new = {rem_q, sh_q[W-1:W-8]};
    prod = 34'(x_new) * 34'(recip);
    qp = 20'(q_q) * 20'(p_i);
    diff = x_q - qp[13:0];
    rem_d = rem_q;
    sh_d = sh_q;
    x_d = x_q;
    q_d = q_q;
    cnt_d = cnt_q;
    ph_d = ph_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      sh_d = n_i;
      cnt_d = 4'd8;
      ph_d = 1'b0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!ph_q) begin
        x_d = x_new;
        q_d = prod[33:20];
        sh_d = {sh_q[W-9:0], 8'd0};
        ph_d = 1'b1;
      end else begin
        rem_d = diff[5:0];
        cnt_d = cnt_q - 4'd1;
        ph_d = 1'b0;
        if (cnt_q == 4'd1) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
      ph_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q <= sh_d;
    x_q <= x_d;
    q_q <= q_d;
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == 6'd0);
endmodule
`default_nettype wire

>>> src/miller_rabin_prime_test_64.sv
`default_nettype none
// miller-rabin primality test on one unsigned 64-bit word
// input: s_axis_tdata carries the candidate, output: m_axis_tdata bit 0 is
// is_prime (1 = judged prime). one result word per input word, in order.
// the block takes one word at a time: s_axis_tready is high only while the
// sequencer is idle. trial division by the twelve primes 2..37 runs a
// byte at a time; then n-1 is split into d*2^s; then each of the seven
// witness bases runs a square-and-multiply exponentiation with the
// bit-serial modular multiplier, plus up to s-1 squarings. the multiplier
// sets the rate of a full test. the result sits in an output register
// until m_axis_tready takes it; meanwhile the next word can be taken and
// tested, and its result waits until the output register frees.
// reset clears the sequencer and drops any pending result.
module miller_rabin_prime_test_64 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // [63:0] candidate
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o   // [0] is_prime, [7:1] zero
);
  import mrpt_pkg::*;
  state_e st_q, st_d;
  word_t n_q, n_d, d_q, d_d, e_q, e_d, x_q, x_d, bp_q, bp_d;
  logic [6:0] s_q, s_d, i_q, i_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [BW-1:0] bi_q, bi_d;
  logic res_q, res_d, ov_q, ov_d;
  logic vd_q, vd_d;
  logic go_q, go_d;
  logic mul_start, mul_done, trl_start, trl_done;
  word_t ma, mb, mr, nm1;
  logic tz;
  logic [5:0] p;

  assign nm1 = n_q - 64'd1;
  assign p = small_prime(sp_q);

  mrpt_mulmod u_mul (.clk_i, .rst_ni, .start_i(mul_start), .a_i(ma), .b_i(mb),
                     .m_i(n_q), .done_o(mul_done), .r_o(mr));
  mrpt_trial u_trial (.clk_i, .rst_ni, .start_i(trl_start), .n_i(n_q), .p_i(p),
                      .done_o(trl_done), .zero_o(tz));

  // next state
  always_comb begin
    st_d = st_q; n_d = n_q; d_d = d_q; e_d = e_q; x_d = x_q; bp_d = bp_q;
    s_d = s_q; i_d = i_q; sp_d = sp_q; bi_d = bi_q; res_d = res_q; ov_d = ov_q;
    vd_d = vd_q;
    go_d = 1'b0;
    if (ov_q && m_axis_tready_i) ov_d = 1'b0;
    case (st_q)
      ST_IDLE: if (s_axis_tvalid_i) begin
        n_d = s_axis_tdata_i;
        sp_d = '0;
        if (s_axis_tdata_i < 64'd2) begin
          vd_d = 1'b0; st_d = ST_DONE;
        end else begin
          go_d = 1'b1; st_d = ST_TRIAL;
        end
      end
      ST_TRIAL: if (trl_done) begin
        if (n_q == {58'd0, p}) begin
          vd_d = 1'b1; st_d = ST_DONE;
        end else if (tz) begin
          vd_d = 1'b0; st_d = ST_DONE;
        end else if (sp_q == SPW'(NSP-1)) begin
          d_d = nm1; s_d = '0; st_d = ST_DECOMP;
        end else begin
          sp_d = sp_q + 1'b1; go_d = 1'b1;
        end
      end
      ST_DECOMP: if (d_q[0]) begin
        bi_d = '0; st_d = ST_BASE;
      end else begin
        d_d = d_q >> 1; s_d = s_q + 7'd1;
      end
      ST_BASE: begin
        bp_d = {58'd0, small_prime({1'b0, bi_q})};
        x_d = 64'd1; e_d = d_q;
        st_d = ST_PMUL; go_d = 1'b1;
      end
      ST_PMUL: if (mul_done) begin
        if (e_q[0]) x_d = mr;
        go_d = 1'b1; st_d = ST_PSQR;
      end
      ST_PSQR: if (mul_done) begin
        bp_d = mr; e_d = e_q >> 1;
        if (e_q[63:1] == '0) st_d = ST_CHECK;
        else begin go_d = 1'b1; st_d = ST_PMUL; end
      end
      ST_CHECK: begin
        i_d = 7'd1;
        if (x_q == 64'd1 || x_q == nm1) st_d = ST_SQCHK;
        else if (s_q <= 7'd1) begin vd_d = 1'b0; st_d = ST_DONE; end
        else begin go_d = 1'b1; st_d = ST_SQR; end
      end
      ST_SQR: if (mul_done) begin
        x_d = mr;
        if (mr == nm1) st_d = ST_SQCHK;
        else if (i_q + 7'd1 >= s_q) begin vd_d = 1'b0; st_d = ST_DONE; end
        else begin i_d = i_q + 7'd1; go_d = 1'b1; end
      end
      ST_SQCHK: begin
        // base passed
        if (bi_q == BW'(NB-1)) begin vd_d = 1'b1; st_d = ST_DONE; end
        else begin bi_d = bi_q + 1'b1; st_d = ST_BASE; end
      end
      // hand the verdict over once the output register is free or draining
      ST_DONE: if (!ov_q || m_axis_tready_i) begin
        ov_d = 1'b1; res_d = vd_q; st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // unit controls and operands
  always_comb begin
    mul_start = go_q && (st_q == ST_PMUL || st_q == ST_PSQR || st_q == ST_SQR);
    trl_start = go_q && (st_q == ST_TRIAL);
    ma = x_q;
    mb = bp_q;
    case (st_q)
      ST_PMUL: begin ma = x_q; mb = bp_q; end
      ST_PSQR: begin ma = bp_q; mb = bp_q; end
      ST_SQR: begin ma = x_q; mb = x_q; end
      default: begin ma = x_q; mb = bp_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
      go_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      go_q <= go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; e_q <= e_d; x_q <= x_d; bp_q <= bp_d;
    s_q <= s_d; i_q <= i_d; sp_q <= sp_d; bi_q <= bi_d; res_q <= res_d;
    vd_q <= vd_d;
  end

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o = {7'd0, res_q};
endmodule
`default_nettype wire
